FILE: design/rtlnh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtlnh_pkg
// Shared types, constants and helpers for the nearest ray-triangle hit block.
// ----------------------------------------------------------------------------
package rtlnh_pkg;

  localparam int MAX_TRIANGLES_DEF = 65536;
  localparam int FRAC_BITS_DEF     = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int COORD_W    = 32;
  localparam int DIR_W      = 18;
  localparam int EPS_W      = 16;
  localparam int EDGE_W     = 33;
  localparam int IDX_W      = 16;
  localparam int T_W        = 31;
  localparam int NUM_UOPS   = 24;
  localparam int UOP_W      = 5;

  typedef logic signed [63:0] sval_t;

  localparam sval_t             SMAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SMAX65 = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic [T_W-1:0]     T_CAP  = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5,
    REG_DET_EPS  = 3'd6
  } cfg_reg_t;

  // one queued request: edges and origin offset, list position, last flag
  typedef struct packed {
    logic [2:0][EDGE_W-1:0] e1;
    logic [2:0][EDGE_W-1:0] e2;
    logic [2:0][EDGE_W-1:0] tv;
    logic                   last;
    logic [IDX_W-1:0]       idx;
  } job_t;

  typedef enum logic [4:0] {
    SRC_E1_0, SRC_E1_1, SRC_E1_2,
    SRC_E2_0, SRC_E2_1, SRC_E2_2,
    SRC_TV_0, SRC_TV_1, SRC_TV_2,
    SRC_DIR_0, SRC_DIR_1, SRC_DIR_2,
    SRC_PV_0, SRC_PV_1, SRC_PV_2,
    SRC_QV_0, SRC_QV_1, SRC_QV_2
  } src_t;

  typedef enum logic [3:0] {
    R_PV0, R_PV1, R_PV2, R_DET, R_NU, R_QV0, R_QV1, R_QV2, R_NV, R_NT
  } dst_t;

  typedef struct packed {
    src_t a;
    src_t b;
    logic neg;
    dst_t dst;
    logic first;
  } uop_t;

  function automatic uop_t uop_rom(logic [UOP_W-1:0] s);
    uop_t u;
    unique case (s)
      5'd0:  u = '{SRC_DIR_1, SRC_E2_2, 1'b0, R_PV0, 1'b1};
      5'd1:  u = '{SRC_DIR_2, SRC_E2_1, 1'b1, R_PV0, 1'b0};
      5'd2:  u = '{SRC_DIR_2, SRC_E2_0, 1'b0, R_PV1, 1'b1};
      5'd3:  u = '{SRC_DIR_0, SRC_E2_2, 1'b1, R_PV1, 1'b0};
      5'd4:  u = '{SRC_DIR_0, SRC_E2_1, 1'b0, R_PV2, 1'b1};
      5'd5:  u = '{SRC_DIR_1, SRC_E2_0, 1'b1, R_PV2, 1'b0};
      5'd6:  u = '{SRC_E1_0,  SRC_PV_0, 1'b0, R_DET, 1'b1};
      5'd7:  u = '{SRC_E1_1,  SRC_PV_1, 1'b0, R_DET, 1'b0};
      5'd8:  u = '{SRC_E1_2,  SRC_PV_2, 1'b0, R_DET, 1'b0};
      5'd9:  u = '{SRC_TV_0,  SRC_PV_0, 1'b0, R_NU,  1'b1};
      5'd10: u = '{SRC_TV_1,  SRC_PV_1, 1'b0, R_NU,  1'b0};
      5'd11: u = '{SRC_TV_2,  SRC_PV_2, 1'b0, R_NU,  1'b0};
      5'd12: u = '{SRC_TV_1,  SRC_E1_2, 1'b0, R_QV0, 1'b1};
      5'd13: u = '{SRC_TV_2,  SRC_E1_1, 1'b1, R_QV0, 1'b0};
      5'd14: u = '{SRC_TV_2,  SRC_E1_0, 1'b0, R_QV1, 1'b1};
      5'd15: u = '{SRC_TV_0,  SRC_E1_2, 1'b1, R_QV1, 1'b0};
      5'd16: u = '{SRC_TV_0,  SRC_E1_1, 1'b0, R_QV2, 1'b1};
      5'd17: u = '{SRC_TV_1,  SRC_E1_0, 1'b1, R_QV2, 1'b0};
      5'd18: u = '{SRC_DIR_0, SRC_QV_0, 1'b0, R_NV,  1'b1};
      5'd19: u = '{SRC_DIR_1, SRC_QV_1, 1'b0, R_NV,  1'b0};
      5'd20: u = '{SRC_DIR_2, SRC_QV_2, 1'b0, R_NV,  1'b0};
      5'd21: u = '{SRC_E2_0,  SRC_QV_0, 1'b0, R_NT,  1'b1};
      5'd22: u = '{SRC_E2_1,  SRC_QV_1, 1'b0, R_NT,  1'b0};
      5'd23: u = '{SRC_E2_2,  SRC_QV_2, 1'b0, R_NT,  1'b0};
      default: u = '{SRC_E1_0, SRC_E1_0, 1'b0, R_PV0, 1'b1};
    endcase
    return u;
  endfunction

  // saturates to +-(2^63-1)
  function automatic sval_t sat_add(sval_t a, sval_t b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s > SMAX65) return SMAX;
    else if (s < -SMAX65) return -SMAX;
    else return s[63:0];
  endfunction

endpackage

FILE: design/rtlnh_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtlnh interfaces
// Triangle, result and register-write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rtlnh_tri_if;
  import rtlnh_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] a_x, a_y, a_z;
  logic signed [COORD_W-1:0] b_x, b_y, b_z;
  logic signed [COORD_W-1:0] c_x, c_y, c_z;
  logic                      last_tri;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  last_tri, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                last_tri, output ready);
endinterface

interface rtlnh_res_if;
  import rtlnh_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      hit_found;
  logic [T_W-1:0]            nearest_t;
  logic [IDX_W-1:0]          nearest_index;
  logic signed [COORD_W-1:0] point_x, point_y, point_z;
  modport source (output valid, hit_found, nearest_t, nearest_index, point_x,
                  point_y, point_z, input ready);
  modport sink (input valid, hit_found, nearest_t, nearest_index, point_x,
                point_y, point_z, output ready);
endinterface

interface rtlnh_cfg_if;
  import rtlnh_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/ray_triangle_list_nearest_hit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_list_nearest_hit
// Nearest ray-triangle hit over a triangle stream, one result per mesh.
// Per triangle: 24 passes through the one multiplier (plus 3 for the hit
// point on a new nearest hit) and, on a hit, a 31-step divider for t that is
// skipped when t saturates. The FIFO between front and back queues two
// triangles. The result is registered once the last triangle completes.
// Reset (rst, synchronous): no hit kept, list position 0, origin 0,
// direction (1,0,0), epsilon 1; no result pending.
// ----------------------------------------------------------------------------
module ray_triangle_list_nearest_hit #(
  parameter int MAX_TRIANGLES = rtlnh_pkg::MAX_TRIANGLES_DEF,
  parameter int FRAC_BITS     = rtlnh_pkg::FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  rtlnh_tri_if.sink   triangle,
  rtlnh_res_if.source result,
  rtlnh_cfg_if.sink   cfg
);
  import rtlnh_pkg::*;

  logic signed [COORD_W-1:0] origin_x, origin_y, origin_z;
  logic signed [DIR_W-1:0]   dir_x, dir_y, dir_z;
  logic [EPS_W-1:0]          det_epsilon;

  job_t fj;
  logic fj_valid;
  logic fj_ready;
  job_t bj;
  logic bj_valid;
  logic bj_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      origin_y    <= '0;
      origin_z    <= '0;
      dir_x       <= DIR_W'(1 << FRAC_BITS);
      dir_y       <= '0;
      dir_z       <= '0;
      det_epsilon <= EPS_W'(1);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ORIGIN_X: origin_x    <= cfg.data;
        REG_ORIGIN_Y: origin_y    <= cfg.data;
        REG_ORIGIN_Z: origin_z    <= cfg.data;
        REG_DIR_X:    dir_x       <= cfg.data[DIR_W-1:0];
        REG_DIR_Y:    dir_y       <= cfg.data[DIR_W-1:0];
        REG_DIR_Z:    dir_z       <= cfg.data[DIR_W-1:0];
        REG_DET_EPS:  det_epsilon <= cfg.data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  rtlnh_front #(.MAX_TRIANGLES(MAX_TRIANGLES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .triangle  (triangle),
    .origin_x  (origin_x),
    .origin_y  (origin_y),
    .origin_z  (origin_z),
    .job       (fj),
    .job_valid (fj_valid),
    .job_ready (fj_ready)
  );

  rtlnh_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fj_valid),
    .push_ready (fj_ready),
    .push_data  (fj),
    .pop_valid  (bj_valid),
    .pop_ready  (bj_ready),
    .pop_data   (bj)
  );

  rtlnh_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .job         (bj),
    .job_valid   (bj_valid),
    .job_ready   (bj_ready),
    .origin_x    (origin_x),
    .origin_y    (origin_y),
    .origin_z    (origin_z),
    .dir_x       (dir_x),
    .dir_y       (dir_y),
    .dir_z       (dir_z),
    .det_epsilon (det_epsilon),
    .result      (result)
  );

endmodule

FILE: design/rtlnh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtlnh_front
// Takes triangles, forms edges and origin offset, tags list position.
// ----------------------------------------------------------------------------
module rtlnh_front #(
  parameter int MAX_TRIANGLES = rtlnh_pkg::MAX_TRIANGLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  rtlnh_tri_if.sink                     triangle,
  input  logic signed [31:0]            origin_x,
  input  logic signed [31:0]            origin_y,
  input  logic signed [31:0]            origin_z,
  output rtlnh_pkg::job_t               job,
  output logic                          job_valid,
  input  logic                          job_ready
);
  import rtlnh_pkg::*;

  localparam int CNT_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [31:0]      cnt_ext;
  logic             accept;

  function automatic logic [EDGE_W-1:0] diff(logic signed [31:0] p,
                                             logic signed [31:0] q);
    return {p[31], p} - {q[31], q};
  endfunction

  assign accept          = triangle.valid & job_ready;
  assign triangle.ready  = job_ready;
  assign job_valid       = triangle.valid;
  assign cnt_ext         = 32'(cnt);

  always_comb begin
    job.e1[0] = diff(triangle.b_x, triangle.a_x);
    job.e1[1] = diff(triangle.b_y, triangle.a_y);
    job.e1[2] = diff(triangle.b_z, triangle.a_z);
    job.e2[0] = diff(triangle.c_x, triangle.a_x);
    job.e2[1] = diff(triangle.c_y, triangle.a_y);
    job.e2[2] = diff(triangle.c_z, triangle.a_z);
    job.tv[0] = diff(origin_x, triangle.a_x);
    job.tv[1] = diff(origin_y, triangle.a_y);
    job.tv[2] = diff(origin_z, triangle.a_z);
    job.last  = triangle.last_tri;
    job.idx   = cnt_ext[IDX_W-1:0];
  end

  always_comb begin
    if (triangle.last_tri) begin
      cnt_next = '0;
    end else if ({1'b0, cnt_ext} + 33'd1 >= 33'(MAX_TRIANGLES)) begin
      cnt_next = '0;
    end else begin
      cnt_next = cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= cnt_next;
    end
  end

endmodule

FILE: design/rtlnh_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtlnh_fifo
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module rtlnh_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  rtlnh_pkg::job_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output rtlnh_pkg::job_t pop_data
);
  import rtlnh_pkg::*;

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

FILE: design/rtlnh_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtlnh_mul
// Signed fixed-point multiply, four 32x32 partial products, truncate and
// saturate. Result appears with done.
// ----------------------------------------------------------------------------
module rtlnh_mul #(
  parameter int FRAC_BITS = rtlnh_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  rtlnh_pkg::sval_t a,
  input  rtlnh_pkg::sval_t b,
  output logic             done,
  output rtlnh_pkg::sval_t result
);
  import rtlnh_pkg::*;

  logic [63:0]  ma;
  logic [63:0]  mb;
  logic         neg;
  logic [1:0]   phase;
  logic         busy;
  logic         fin;
  logic [127:0] acc;
  logic [31:0]  op_a;
  logic [31:0]  op_b;
  logic [63:0]  prod;
  logic [127:0] prod_sh;
  logic [127:0] scaled;
  logic [62:0]  mag_r;

  always_comb begin
    op_a    = phase[0] ? ma[63:32] : ma[31:0];
    op_b    = phase[1] ? mb[63:32] : mb[31:0];
    prod    = op_a * op_b;
    unique case (phase)
      2'd0:    prod_sh = 128'(prod);
      2'd1,
      2'd2:    prod_sh = 128'(prod) << 32;
      default: prod_sh = 128'(prod) << 64;
    endcase
    scaled = acc >> FRAC_BITS;
    mag_r  = (|scaled[127:63]) ? SMAX[62:0] : scaled[62:0];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma    <= a[63] ? 64'(-a) : 64'(a);
      mb    <= b[63] ? 64'(-b) : 64'(b);
      neg   <= a[63] ^ b[63];
      acc   <= '0;
      phase <= 2'd0;
    end else if (busy) begin
      acc   <= acc + prod_sh;
      phase <= phase + 2'd1;
    end
    if (fin) begin
      result <= neg ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fin;
      fin  <= busy && (phase == 2'd3);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && phase == 2'd3) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

FILE: design/rtlnh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtlnh_back
// Sequences the intersection test over the shared multiplier, divides for t,
// keeps the nearest hit and holds the result register.
// ----------------------------------------------------------------------------
module rtlnh_back #(
  parameter int FRAC_BITS = rtlnh_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  rtlnh_pkg::job_t         job,
  input  logic                    job_valid,
  output logic                    job_ready,
  input  logic signed [31:0]      origin_x,
  input  logic signed [31:0]      origin_y,
  input  logic signed [31:0]      origin_z,
  input  logic signed [17:0]      dir_x,
  input  logic signed [17:0]      dir_y,
  input  logic signed [17:0]      dir_z,
  input  logic [15:0]             det_epsilon,
  rtlnh_res_if.source             result
);
  import rtlnh_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_ISSUE  = 9'b000000010,
    S_WAIT   = 9'b000000100,
    S_TEST   = 9'b000001000,
    S_DIV    = 9'b000010000,
    S_UPD    = 9'b000100000,
    S_PISSUE = 9'b001000000,
    S_PWAIT  = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t           state;
  job_t             cur;
  logic [UOP_W-1:0] step;
  sval_t            acc [10];
  logic [95:0]      rem;
  logic [95:0]      dsh;
  logic [T_W-1:0]   quo;
  logic [4:0]       dcnt;
  logic [1:0]       pk;
  logic [T_W-1:0]   best_t;
  logic [IDX_W-1:0] best_index;
  logic             any_hit;
  logic [31:0]      best_pt [3];

  uop_t   uop;
  sval_t  mul_a;
  sval_t  mul_b;
  logic   mul_start;
  logic   mul_done;
  sval_t  mul_res;
  sval_t  term;
  sval_t  det_f;
  sval_t  nu_f;
  sval_t  nv_f;
  sval_t  nt_f;
  logic   flip;
  logic   hit;
  logic   cap;
  logic   div_ge;
  sval_t  pt_sum;
  sval_t  org_k;
  sval_t  dir_k;
  logic   emit;

  function automatic sval_t sx33(logic [EDGE_W-1:0] v);
    return {{(64 - EDGE_W){v[EDGE_W-1]}}, v};
  endfunction

  function automatic sval_t sx18(logic [17:0] v);
    return {{46{v[17]}}, v};
  endfunction

  function automatic logic [31:0] clamp32(sval_t v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    else if (v < -64'sd2147483648) return 32'h8000_0000;
    else return v[31:0];
  endfunction

  function automatic sval_t src_val(src_t s);
    sval_t v;
    unique case (s)
      SRC_E1_0:  v = sx33(cur.e1[0]);
      SRC_E1_1:  v = sx33(cur.e1[1]);
      SRC_E1_2:  v = sx33(cur.e1[2]);
      SRC_E2_0:  v = sx33(cur.e2[0]);
      SRC_E2_1:  v = sx33(cur.e2[1]);
      SRC_E2_2:  v = sx33(cur.e2[2]);
      SRC_TV_0:  v = sx33(cur.tv[0]);
      SRC_TV_1:  v = sx33(cur.tv[1]);
      SRC_TV_2:  v = sx33(cur.tv[2]);
      SRC_DIR_0: v = sx18(dir_x);
      SRC_DIR_1: v = sx18(dir_y);
      SRC_DIR_2: v = sx18(dir_z);
      SRC_PV_0:  v = acc[R_PV0];
      SRC_PV_1:  v = acc[R_PV1];
      SRC_PV_2:  v = acc[R_PV2];
      SRC_QV_0:  v = acc[R_QV0];
      SRC_QV_1:  v = acc[R_QV1];
      SRC_QV_2:  v = acc[R_QV2];
      default:   v = '0;
    endcase
    return v;
  endfunction

  rtlnh_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  always_comb begin
    uop = uop_rom(step);
    unique case (pk)
      2'd0:    begin org_k = {{32{origin_x[31]}}, origin_x}; dir_k = sx18(dir_x); end
      2'd1:    begin org_k = {{32{origin_y[31]}}, origin_y}; dir_k = sx18(dir_y); end
      default: begin org_k = {{32{origin_z[31]}}, origin_z}; dir_k = sx18(dir_z); end
    endcase
    if (state == S_PISSUE) begin
      mul_a = dir_k;
      mul_b = {33'b0, best_t};
    end else begin
      mul_a = src_val(uop.a);
      mul_b = src_val(uop.b);
    end
    mul_start = (state == S_ISSUE) || (state == S_PISSUE);
    term      = uop.neg ? -mul_res : mul_res;
    pt_sum    = sat_add(org_k, mul_res);

    flip  = acc[R_DET][63];
    det_f = flip ? -acc[R_DET] : acc[R_DET];
    nu_f  = flip ? -acc[R_NU]  : acc[R_NU];
    nv_f  = flip ? -acc[R_NV]  : acc[R_NV];
    nt_f  = flip ? -acc[R_NT]  : acc[R_NT];
    hit   = (det_f > $signed({48'b0, det_epsilon})) && !nu_f[63] && (nu_f <= det_f) &&
            !nv_f[63] && (sat_add(nu_f, nv_f) <= det_f) && !nt_f[63];
    cap   = (({32'b0, nt_f} << FRAC_BITS) >= ({32'b0, det_f} << 31));
    div_ge = (rem >= dsh);

    job_ready = (state == S_IDLE);
    emit      = (state == S_DONE) && cur.last && (!result.valid || result.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= '0;
      pk         <= 2'd0;
      best_t     <= T_CAP;
      best_index <= '0;
      any_hit    <= 1'b0;
      best_pt    <= '{default: '0};
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            step  <= '0;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (mul_done) begin
            if (step == UOP_W'(NUM_UOPS - 1)) begin
              state <= S_TEST;
            end else begin
              step  <= step + UOP_W'(1);
              state <= S_ISSUE;
            end
          end
        end
        S_TEST: begin
          if (!hit) state <= S_DONE;
          else if (cap) state <= S_UPD;
          else state <= S_DIV;
        end
        S_DIV: begin
          if (dcnt == 5'd0) state <= S_UPD;
        end
        S_UPD: begin
          if (!any_hit || quo < best_t) begin
            any_hit    <= 1'b1;
            best_t     <= quo;
            best_index <= cur.idx;
            pk         <= 2'd0;
            state      <= S_PISSUE;
          end else begin
            state <= S_DONE;
          end
        end
        S_PISSUE: begin
          state <= S_PWAIT;
        end
        S_PWAIT: begin
          if (mul_done) begin
            best_pt[pk] <= clamp32(pt_sum);
            if (pk == 2'd2) begin
              state <= S_DONE;
            end else begin
              pk    <= pk + 2'd1;
              state <= S_PISSUE;
            end
          end
        end
        S_DONE: begin
          if (!cur.last) begin
            state <= S_IDLE;
          end else if (emit) begin
            best_t     <= T_CAP;
            best_index <= '0;
            any_hit    <= 1'b0;
            best_pt    <= '{default: '0};
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && job_valid) begin
      cur <= job;
    end
    if (state == S_WAIT && mul_done) begin
      acc[uop.dst] <= sat_add(uop.first ? '0 : acc[uop.dst], term);
    end
    if (state == S_TEST) begin
      quo  <= T_CAP;
      rem  <= {32'b0, nt_f} << FRAC_BITS;
      dsh  <= {32'b0, det_f} << (T_W - 1);
      dcnt <= 5'(T_W - 1);
    end else if (state == S_DIV) begin
      if (div_ge) rem <= rem - dsh;
      quo  <= {quo[T_W-2:0], div_ge};
      dsh  <= dsh >> 1;
      dcnt <= dcnt - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.hit_found     <= any_hit;
      result.nearest_t     <= best_t;
      result.nearest_index <= best_index;
      result.point_x       <= best_pt[0];
      result.point_y       <= best_pt[1];
      result.point_z       <= best_pt[2];
    end
  end

endmodule

FILE: design/rtlnh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtlnh_checker
// Port-level checks on the result and register-write channels.
// ----------------------------------------------------------------------------
module rtlnh_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        hit_found,
  input logic [30:0] nearest_t,
  input logic [15:0] nearest_index,
  input logic [31:0] point_x,
  input logic [31:0] point_y,
  input logic [31:0] point_z,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result request dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(nearest_t) && $stable(nearest_index) &&
      $stable(hit_found) && $stable(point_x) && $stable(point_y) && $stable(point_z))
    else $error("result payload moved while stalled");

  a_miss_clear: assert property (@(posedge clk) disable iff (rst)
    res_valid && !hit_found |-> nearest_t == '1 && nearest_index == '0 &&
      point_x == '0 && point_y == '0 && point_z == '0)
    else $error("miss result carries stale hit data");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("register write not taken");

endmodule

bind ray_triangle_list_nearest_hit rtlnh_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .hit_found     (result.hit_found),
  .nearest_t     (result.nearest_t),
  .nearest_index (result.nearest_index),
  .point_x       (result.point_x),
  .point_y       (result.point_y),
  .point_z       (result.point_z),
  .cfg_valid     (cfg.valid),
  .cfg_ready     (cfg.ready)
);
